@@ rtl/core/rgbfx_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// rgbfx_pkg
// Shared types, constants and helpers for the RGB LED effect generator.
// ----------------------------------------------------------------------------
package rgbfx_pkg;

  // Effect tuning
  localparam int unsigned FADE_PEAK    = 150;
  localparam int unsigned BREATH_MAX   = 100;
  localparam int unsigned PALETTE_SIZE = 4;

  // Field widths
  localparam int unsigned COLOR_W   = 24;
  localparam int unsigned CHAN_W    = 8;
  localparam int unsigned TICK_W    = 16;
  localparam int unsigned LEVEL_W   = 7;
  localparam int unsigned PROD_W    = LEVEL_W + CHAN_W;
  localparam int unsigned CFG_IDX_W = 3;

  // Divide by BREATH_MAX as multiply by reciprocal; exact for products below 2^22/BREATH_MAX
  localparam int unsigned DIV_SHIFT = 22;
  localparam int unsigned DIV_MULT  = ((1 << DIV_SHIFT) + BREATH_MAX - 1) / BREATH_MAX;
  localparam int unsigned DIV_PW    = 40;

  typedef enum logic [1:0] {
    MODE_OFF    = 2'd0,
    MODE_SOLID  = 2'd1,
    MODE_BREATH = 2'd2,
    MODE_NEON   = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    PH_RED    = 2'd0,
    PH_BLUE   = 2'd1,
    PH_GREEN  = 2'd2,
    PH_UNUSED = 2'd3
  } phase_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MODE       = 3'd0,
    REG_SPEED      = 3'd1,
    REG_BRIGHTNESS = 3'd2,
    REG_SOLID      = 3'd3,
    REG_PAL0       = 3'd4,
    REG_PAL1       = 3'd5,
    REG_PAL2       = 3'd6,
    REG_PAL3       = 3'd7
  } cfg_idx_t;

  // Step delay in ticks, speed 1 slowest .. 4 fastest; anything else acts as 3
  function automatic logic [3:0] breath_delay(input logic [2:0] speed);
    logic [3:0] d;
    case (speed)
      3'd1:    d = 4'd15;
      3'd2:    d = 4'd10;
      3'd4:    d = 4'd3;
      default: d = 4'd5;
    endcase
    return d;
  endfunction

  function automatic logic [3:0] neon_delay(input logic [2:0] speed);
    logic [3:0] d;
    case (speed)
      3'd1:    d = 4'd8;
      3'd2:    d = 4'd6;
      3'd4:    d = 4'd2;
      default: d = 4'd4;
    endcase
    return d;
  endfunction

  // floor(x / BREATH_MAX)
  function automatic logic [CHAN_W-1:0] div_breath(input logic [PROD_W-1:0] x);
    logic [DIV_PW-1:0] p;
    p = DIV_PW'(x) * DIV_PW'(DIV_MULT);
    return CHAN_W'(p >> DIV_SHIFT);
  endfunction

endpackage
`default_nettype wire

@@ rtl/core/rgb_led_effect_generator_core.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// rgb_led_effect_generator_core
// One RGB drive value per item: off, solid, breath and neon fade effects.
// ----------------------------------------------------------------------------
//
//  channel  | signals                                   | direction
//  ---------+-------------------------------------------+----------
//  in       | in_valid, in_ready, in_restart            | item in
//  out      | out_valid, out_ready, out_lights_on,      | result out
//           | out_red_level/green_level/blue_level      |
//  cfg      | cfg_we, cfg_index, cfg_wdata              | reg write
//
//  Input, product and result registers share one enable: each item passes
//  through all three, one accepted every cycle while no result stalls.
//  Breath multiply feeds the product register, the reciprocal divide by
//  BREATH_MAX the result register; effect state commits as an item leaves
//  the input register. A stalled result freezes the pipe and drops in_ready.
//  rst_n: synchronous, active low, clears control and effect state.
//
module rgb_led_effect_generator_core (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  // input items
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic                          in_restart,
  // result items
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic                               out_lights_on,
  output logic [rgbfx_pkg::CHAN_W-1:0]       out_red_level,
  output logic [rgbfx_pkg::CHAN_W-1:0]       out_green_level,
  output logic [rgbfx_pkg::CHAN_W-1:0]       out_blue_level,
  // configuration
  input  wire logic                          cfg_we,
  input  wire logic [rgbfx_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [rgbfx_pkg::COLOR_W-1:0] cfg_wdata
);

  localparam int unsigned CW = rgbfx_pkg::CHAN_W;
  localparam int unsigned PW = rgbfx_pkg::PROD_W;
  localparam int unsigned LW = rgbfx_pkg::LEVEL_W;
  localparam int unsigned TW = rgbfx_pkg::TICK_W;

  // ---------------- configuration registers ----------------
  rgbfx_pkg::mode_t                mode_r;
  logic [2:0]                      speed_r;
  logic [1:0]                      bright_r;
  logic [rgbfx_pkg::COLOR_W-1:0]   solid_r;
  logic [rgbfx_pkg::COLOR_W-1:0]   pal_r [4];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= rgbfx_pkg::MODE_OFF;
      speed_r  <= 3'd3;
      bright_r <= 2'd3;
      solid_r  <= '0;
      for (int i = 0; i < 4; i++) pal_r[i] <= '0;
    end else if (cfg_we) begin
      unique case (rgbfx_pkg::cfg_idx_t'(cfg_index))
        rgbfx_pkg::REG_MODE:       mode_r   <= rgbfx_pkg::mode_t'(cfg_wdata[1:0]);
        rgbfx_pkg::REG_SPEED:      speed_r  <= cfg_wdata[2:0];
        rgbfx_pkg::REG_BRIGHTNESS: bright_r <= cfg_wdata[1:0];
        rgbfx_pkg::REG_SOLID:      solid_r  <= cfg_wdata;
        rgbfx_pkg::REG_PAL0:       pal_r[0] <= cfg_wdata;
        rgbfx_pkg::REG_PAL1:       pal_r[1] <= cfg_wdata;
        rgbfx_pkg::REG_PAL2:       pal_r[2] <= cfg_wdata;
        rgbfx_pkg::REG_PAL3:       pal_r[3] <= cfg_wdata;
      endcase
    end
  end

  // ---------------- pipeline control ----------------
  // Single enable: everything moves unless a result is waiting.
  logic adv;
  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;

  // Stage 1: input register
  logic s1_valid_r, s1_restart_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (adv) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_restart_r <= in_restart;
    end
  end

  // ---------------- effect state ----------------
  logic [TW-1:0]       tick_r,  tick_nxt;
  rgbfx_pkg::phase_t   phase_r, phase_nxt;
  logic [CW-1:0]       fr_r, fg_r, fb_r, fr_nxt, fg_nxt, fb_nxt;
  logic [LW-1:0]       level_r, level_nxt;
  logic                fall_r, fall_nxt;
  logic [1:0]          pidx_r, pidx_nxt;

  // values headed for stage 2
  logic                on_c, div_c;
  logic [PW-1:0]       vr_c, vg_c, vb_c;

  function automatic logic [CW-1:0] toward(input logic [CW-1:0] v, input logic up);
    logic [CW-1:0] r;
    if (up) r = (v < CW'(rgbfx_pkg::FADE_PEAK)) ? v + CW'(1) : v;
    else    r = (v != '0) ? v - CW'(1) : v;
    return r;
  endfunction

  function automatic logic [CW-1:0] solid_scale(input logic [CW-1:0] c,
                                                input logic [1:0] br);
    logic [CW+1:0] c3;
    logic [CW-1:0] r;
    c3 = (CW+2)'(c) * (CW+2)'(3);
    unique case (br)
      2'd0: r = c >> 2;
      2'd1: r = c >> 1;
      2'd2: r = CW'(c3 >> 2);
      2'd3: r = c;
    endcase
    return r;
  endfunction

  always_comb begin
    logic [rgbfx_pkg::COLOR_W-1:0] col;
    logic [CW-1:0]                 pk;
    logic                          step;
    logic [1:0]                    pinc;

    tick_nxt  = tick_r;
    phase_nxt = phase_r;
    fr_nxt    = fr_r;
    fg_nxt    = fg_r;
    fb_nxt    = fb_r;
    level_nxt = level_r;
    fall_nxt  = fall_r;
    pidx_nxt  = pidx_r;
    on_c      = 1'b1;
    div_c     = 1'b0;
    vr_c      = '0;
    vg_c      = '0;
    vb_c      = '0;
    pk        = CW'(rgbfx_pkg::FADE_PEAK);
    step      = 1'b0;
    pinc      = pidx_r + 2'd1;
    col       = '0;

    if (s1_restart_r) begin
      tick_nxt  = '0;
      phase_nxt = rgbfx_pkg::PH_RED;
      fr_nxt    = '0;
      fg_nxt    = '0;
      fb_nxt    = '0;
      level_nxt = '0;
      fall_nxt  = 1'b0;
      pidx_nxt  = '0;
    end else if (tick_r != {TW{1'b1}}) begin
      tick_nxt = tick_r + TW'(1);
    end

    unique case (mode_r)
      rgbfx_pkg::MODE_OFF: begin
        on_c = 1'b0;
      end
      rgbfx_pkg::MODE_SOLID: begin
        vr_c = PW'(solid_scale(solid_r[23:16], bright_r));
        vg_c = PW'(solid_scale(solid_r[15:8],  bright_r));
        vb_c = PW'(solid_scale(solid_r[7:0],   bright_r));
      end
      rgbfx_pkg::MODE_BREATH: begin
        // output from the level before this item's step
        div_c = 1'b1;
        col   = pal_r[pidx_nxt];
        vr_c  = PW'(level_nxt) * PW'(col[23:16]);
        vg_c  = PW'(level_nxt) * PW'(col[15:8]);
        vb_c  = PW'(level_nxt) * PW'(col[7:0]);
        step  = !s1_restart_r && (tick_nxt >= TW'(rgbfx_pkg::breath_delay(speed_r)));
        if (step) begin
          tick_nxt = '0;
          if (!fall_r) begin
            if (level_r < LW'(rgbfx_pkg::BREATH_MAX)) level_nxt = level_r + LW'(1);
            else                                      fall_nxt  = 1'b1;
          end else begin
            if (level_r != '0) begin
              level_nxt = level_r - LW'(1);
            end else begin
              fall_nxt = 1'b0;
              pidx_nxt = ({1'b0, pinc} >= 3'(rgbfx_pkg::PALETTE_SIZE)) ? 2'd0 : pinc;
            end
          end
        end
      end
      rgbfx_pkg::MODE_NEON: begin
        step = !s1_restart_r && (tick_nxt >= TW'(rgbfx_pkg::neon_delay(speed_r)));
        if (step) begin
          tick_nxt = '0;
          unique case (phase_r)
            rgbfx_pkg::PH_BLUE: begin
              if (fr_r == '0 && fg_r == '0 && fb_r == pk) begin
                phase_nxt = rgbfx_pkg::PH_GREEN;
              end else begin
                fr_nxt = toward(fr_r, 1'b0);
                fg_nxt = toward(fg_r, 1'b0);
                fb_nxt = toward(fb_r, 1'b1);
              end
            end
            rgbfx_pkg::PH_GREEN: begin
              if (fr_r == '0 && fg_r == pk && fb_r == '0) begin
                phase_nxt = rgbfx_pkg::PH_RED;
              end else begin
                fr_nxt = toward(fr_r, 1'b0);
                fg_nxt = toward(fg_r, 1'b1);
                fb_nxt = toward(fb_r, 1'b0);
              end
            end
            rgbfx_pkg::PH_RED, rgbfx_pkg::PH_UNUSED: begin
              // unused code runs as the red phase
              if (fr_r == pk && fg_r == '0 && fb_r == '0) begin
                phase_nxt = rgbfx_pkg::PH_BLUE;
              end else begin
                fr_nxt = toward(fr_r, 1'b1);
                fg_nxt = toward(fg_r, 1'b0);
                fb_nxt = toward(fb_r, 1'b0);
              end
            end
          endcase
        end
        vr_c = PW'(fr_nxt);
        vg_c = PW'(fg_nxt);
        vb_c = PW'(fb_nxt);
      end
    endcase
  end

  // state commits as the item moves into stage 2
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_r  <= '0;
      phase_r <= rgbfx_pkg::PH_RED;
      fr_r    <= '0;
      fg_r    <= '0;
      fb_r    <= '0;
      level_r <= '0;
      fall_r  <= 1'b0;
      pidx_r  <= '0;
    end else if (adv && s1_valid_r) begin
      tick_r  <= tick_nxt;
      phase_r <= phase_nxt;
      fr_r    <= fr_nxt;
      fg_r    <= fg_nxt;
      fb_r    <= fb_nxt;
      level_r <= level_nxt;
      fall_r  <= fall_nxt;
      pidx_r  <= pidx_nxt;
    end
  end

  // ---------------- stage 2: products / plain values ----------------
  logic          s2_valid_r, s2_on_r, s2_div_r;
  logic [PW-1:0] s2_r_r, s2_g_r, s2_b_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (adv) begin
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_on_r  <= on_c;
      s2_div_r <= div_c;
      s2_r_r   <= vr_c;
      s2_g_r   <= vg_c;
      s2_b_r   <= vb_c;
    end
  end

  // ---------------- stage 3: result register ----------------
  logic          out_valid_r, out_on_r;
  logic [CW-1:0] out_r_r, out_g_r, out_b_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_on_r <= s2_on_r;
      out_r_r  <= s2_div_r ? rgbfx_pkg::div_breath(s2_r_r) : CW'(s2_r_r);
      out_g_r  <= s2_div_r ? rgbfx_pkg::div_breath(s2_g_r) : CW'(s2_g_r);
      out_b_r  <= s2_div_r ? rgbfx_pkg::div_breath(s2_b_r) : CW'(s2_b_r);
    end
  end

  assign out_valid       = out_valid_r;
  assign out_lights_on   = out_on_r;
  assign out_red_level   = out_r_r;
  assign out_green_level = out_g_r;
  assign out_blue_level  = out_b_r;

endmodule
`default_nettype wire

@@ rtl/core/rgbfx_chk.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// rgbfx_chk
// Port-level checks for the RGB LED effect generator, bound to the top level.
// ----------------------------------------------------------------------------
module rgbfx_chk (
  input wire logic                            clk,
  input wire logic                            rst_n,
  input wire logic                            in_ready,
  input wire logic                            out_valid,
  input wire logic                            out_ready,
  input wire logic                            out_lights_on,
  input wire logic [rgbfx_pkg::CHAN_W-1:0]    out_red_level,
  input wire logic [rgbfx_pkg::CHAN_W-1:0]    out_green_level,
  input wire logic [rgbfx_pkg::CHAN_W-1:0]    out_blue_level
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_lights_on) &&
      $stable(out_red_level) && $stable(out_green_level) && $stable(out_blue_level))
    else $error("stalled result changed");

  // dark output carries zero levels
  a_off_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_lights_on |->
      out_red_level == '0 && out_green_level == '0 && out_blue_level == '0)
    else $error("lights off with nonzero level");

  // empty output slot never blocks the input
  a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input blocked with empty output");

  // a waiting result blocks the input
  a_ready_stall: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !in_ready)
    else $error("input taken while result stalled");

endmodule

bind rgb_led_effect_generator_core rgbfx_chk u_rgbfx_chk (.*);
`default_nettype wire

@@ dv/tb_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the RGB LED effect core. A queue-fed driver offers
// tick and restart items, a clocked monitor compares every drive value with a
// cycle-free prediction of the effect state, and register writes happen only
// while the pipe is empty.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int unsigned CW   = rgbfx_pkg::CHAN_W;
  localparam int unsigned COLW = rgbfx_pkg::COLOR_W;
  localparam int unsigned TW   = rgbfx_pkg::TICK_W;
  localparam int unsigned LW   = rgbfx_pkg::LEVEL_W;

  // speed and brightness register values with their own meaning
  localparam logic [2:0] SPEED_SLOW = 3'd1;
  localparam logic [2:0] SPEED_MID  = 3'd2;
  localparam logic [2:0] SPEED_DEF  = 3'd3;
  localparam logic [2:0] SPEED_FAST = 3'd4;
  localparam logic [1:0] DIM_QUARTER = 2'd0;
  localparam logic [1:0] DIM_HALF    = 2'd1;
  localparam logic [1:0] DIM_3QUART  = 2'd2;
  localparam logic [1:0] DIM_FULL    = 2'd3;

  localparam logic [COLW-1:0] WHITE = 24'hFFFFFF;
  localparam logic [COLW-1:0] BLACK = 24'h000000;

  typedef struct packed {
    logic          lights_on;
    logic [CW-1:0] red;
    logic [CW-1:0] green;
    logic [CW-1:0] blue;
  } drive_t;

  // clock, reset and block inputs, all known from time zero
  logic                 clk        = 1'b0;
  logic                 rst_n      = 1'b0;
  logic                 in_valid   = 1'b0;
  logic                 in_restart = 1'b0;
  logic                 out_ready  = 1'b0;
  logic                 cfg_we     = 1'b0;
  rgbfx_pkg::cfg_idx_t  cfg_index  = rgbfx_pkg::REG_MODE;
  logic [COLW-1:0]      cfg_wdata  = '0;

  logic                 in_ready;
  logic                 out_valid;
  logic                 out_lights_on;
  logic [CW-1:0]        out_red_level;
  logic [CW-1:0]        out_green_level;
  logic [CW-1:0]        out_blue_level;

  // items still to be offered, and drive values still to arrive
  logic   pending_restart[$];
  drive_t expected_drive[$];

  // run control shared by driver, monitor and sequencer
  bit idle_on        = 1'b1;
  int mismatch_count = 0;
  int send_gap       = 0;
  int rx_gap         = 0;
  int hold_left      = 0;
  int holds_done     = 0;
  int rx_count       = 0;
  drive_t seen_want;

  // predictor copy of the registers (reset values)
  rgbfx_pkg::mode_t   cur_mode   = rgbfx_pkg::MODE_OFF;
  logic [2:0]         cur_speed  = SPEED_DEF;
  logic [1:0]         cur_bright = DIM_FULL;
  logic [COLW-1:0]    solid_rgb  = '0;
  logic [COLW-1:0]    palette [4] = '{default: '0};

  // predictor copy of the effect state
  logic [TW-1:0]      tick_q   = '0;
  rgbfx_pkg::phase_t  fade_ph  = rgbfx_pkg::PH_RED;
  logic [CW-1:0]      fade_r   = '0;
  logic [CW-1:0]      fade_g   = '0;
  logic [CW-1:0]      fade_b   = '0;
  logic [LW-1:0]      lvl      = '0;
  logic               falling  = 1'b0;
  logic [1:0]         pal_idx  = '0;

  rgb_led_effect_generator_core dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_restart      (in_restart),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_lights_on   (out_lights_on),
    .out_red_level   (out_red_level),
    .out_green_level (out_green_level),
    .out_blue_level  (out_blue_level),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata)
  );

  always #1 clk = ~clk;

  // ticks between effect steps; speeds outside 1..4 behave as the default
  function automatic int step_ticks(input rgbfx_pkg::mode_t m, input logic [2:0] s);
    int neon;
    neon = (m == rgbfx_pkg::MODE_NEON);
    case (s)
      SPEED_SLOW: return neon ? 8 : 15;
      SPEED_MID:  return neon ? 6 : 10;
      SPEED_FAST: return neon ? 2 : 3;
      default:    return neon ? 4 : 5;
    endcase
  endfunction

  // one unit toward the fade peak or toward zero, held at the end stop
  function automatic logic [CW-1:0] nudge(input logic [CW-1:0] v, input bit up);
    if (up)
      return (v < rgbfx_pkg::FADE_PEAK) ? v + 1'b1 : v;
    return (v != '0) ? v - 1'b1 : v;
  endfunction

  function automatic logic [CW-1:0] dim_solid(input logic [CW-1:0] c,
                                              input logic [1:0] b);
    case (b)
      DIM_QUARTER: return CW'(int'(c) / 4);
      DIM_HALF:    return CW'(int'(c) / 2);
      DIM_3QUART:  return CW'((int'(c) * 3) / 4);
      default:     return c;
    endcase
  endfunction

  function automatic logic [COLW-1:0] rand_color();
    case ($urandom_range(0, 5))
      0:       return BLACK;
      1:       return WHITE;
      default: return COLW'($urandom());
    endcase
  endfunction

  // Advance the effect by one accepted item and queue the drive value it
  // must produce. Breath shows the level before its step; neon steps first.
  task automatic predict_drive(input logic restart);
    drive_t          d;
    logic [COLW-1:0] col;
    d = '0;
    d.lights_on = 1'b1;
    if (restart) begin
      tick_q  = '0;
      fade_ph = rgbfx_pkg::PH_RED;
      fade_r  = '0;
      fade_g  = '0;
      fade_b  = '0;
      lvl     = '0;
      falling = 1'b0;
      pal_idx = '0;
    end else if (tick_q != '1) begin
      tick_q = tick_q + 1'b1;
    end

    case (cur_mode)
      rgbfx_pkg::MODE_OFF: begin
        d.lights_on = 1'b0;
      end
      rgbfx_pkg::MODE_SOLID: begin
        d.red   = dim_solid(solid_rgb[23:16], cur_bright);
        d.green = dim_solid(solid_rgb[15:8], cur_bright);
        d.blue  = dim_solid(solid_rgb[7:0], cur_bright);
      end
      rgbfx_pkg::MODE_BREATH: begin
        col     = palette[pal_idx];
        d.red   = CW'((int'(lvl) * int'(col[23:16])) / rgbfx_pkg::BREATH_MAX);
        d.green = CW'((int'(lvl) * int'(col[15:8])) / rgbfx_pkg::BREATH_MAX);
        d.blue  = CW'((int'(lvl) * int'(col[7:0])) / rgbfx_pkg::BREATH_MAX);
        if (!restart && tick_q >= step_ticks(cur_mode, cur_speed)) begin
          if (!falling) begin
            if (lvl < rgbfx_pkg::BREATH_MAX) lvl = lvl + 1'b1;
            else falling = 1'b1;
          end else if (lvl != '0) begin
            lvl = lvl - 1'b1;
          end else begin
            // bottom of the ramp: next palette entry
            falling = 1'b0;
            pal_idx = pal_idx + 1'b1;
            if (pal_idx >= rgbfx_pkg::PALETTE_SIZE) pal_idx = '0;
          end
          tick_q = '0;
        end
      end
      default: begin
        if (!restart && tick_q >= step_ticks(cur_mode, cur_speed)) begin
          tick_q = '0;
          case (fade_ph)
            rgbfx_pkg::PH_BLUE: begin
              if (fade_r == 0 && fade_g == 0 && fade_b == rgbfx_pkg::FADE_PEAK) begin
                fade_ph = rgbfx_pkg::PH_GREEN;
              end else begin
                fade_r = nudge(fade_r, 1'b0);
                fade_g = nudge(fade_g, 1'b0);
                fade_b = nudge(fade_b, 1'b1);
              end
            end
            rgbfx_pkg::PH_GREEN: begin
              if (fade_r == 0 && fade_g == rgbfx_pkg::FADE_PEAK && fade_b == 0) begin
                fade_ph = rgbfx_pkg::PH_RED;
              end else begin
                fade_r = nudge(fade_r, 1'b0);
                fade_g = nudge(fade_g, 1'b1);
                fade_b = nudge(fade_b, 1'b0);
              end
            end
            default: begin
              // red phase; the unused code behaves the same way
              if (fade_r == rgbfx_pkg::FADE_PEAK && fade_g == 0 && fade_b == 0) begin
                fade_ph = rgbfx_pkg::PH_BLUE;
              end else begin
                fade_r = nudge(fade_r, 1'b1);
                fade_g = nudge(fade_g, 1'b0);
                fade_b = nudge(fade_b, 1'b0);
              end
            end
          endcase
        end
        d.red   = fade_r;
        d.green = fade_g;
        d.blue  = fade_b;
      end
    endcase
    expected_drive.push_back(d);
  endtask

  task automatic flag_mismatch(input string what, input int got, input int want);
    $display("[%0t] result %0d: %s got %0d, want %0d", $realtime, rx_count, what, got, want);
    mismatch_count++;
  endtask

  // Driver: register writes land in the predictor at the edge the block
  // takes them; an accepted item is predicted at its accepting edge.
  always @(posedge clk) begin
    if (cfg_we) begin
      case (cfg_index)
        rgbfx_pkg::REG_MODE:       cur_mode   = rgbfx_pkg::mode_t'(cfg_wdata[1:0]);
        rgbfx_pkg::REG_SPEED:      cur_speed  = cfg_wdata[2:0];
        rgbfx_pkg::REG_BRIGHTNESS: cur_bright = cfg_wdata[1:0];
        rgbfx_pkg::REG_SOLID:      solid_rgb  = cfg_wdata;
        default:                   palette[2'(cfg_index - rgbfx_pkg::REG_PAL0)] = cfg_wdata;
      endcase
    end
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) predict_drive(in_restart);
      // a held item stays put; otherwise pick gap or next item
      if (!in_valid || in_ready) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (pending_restart.size() == 0) begin
          in_valid <= 1'b0;
        end else if (idle_on && $urandom_range(0, 5) == 0) begin
          send_gap = $urandom_range(0, 4);
          in_valid <= 1'b0;
        end else begin
          in_valid   <= 1'b1;
          in_restart <= pending_restart.pop_front();
        end
      end
    end
  end

  // Monitor: checks each accepted result and paces out_ready. Twice it
  // holds off for a long stretch while items are still queued, so the pipe
  // fills and in_ready has to drop.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_drive.size() == 0) begin
          flag_mismatch("unexpected result", 0, 0);
        end else begin
          seen_want = expected_drive.pop_front();
          if (out_lights_on !== seen_want.lights_on)
            flag_mismatch("lights_on", out_lights_on, seen_want.lights_on);
          if (out_red_level !== seen_want.red)
            flag_mismatch("red_level", out_red_level, seen_want.red);
          if (out_green_level !== seen_want.green)
            flag_mismatch("green_level", out_green_level, seen_want.green);
          if (out_blue_level !== seen_want.blue)
            flag_mismatch("blue_level", out_blue_level, seen_want.blue);
        end
        rx_count++;
      end

      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (holds_done < 2 && idle_on && pending_restart.size() > 20) begin
        hold_left = 60;
        holds_done++;
        out_ready <= 1'b0;
      end else if (rx_gap > 0) begin
        rx_gap--;
        out_ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        rx_gap = $urandom_range(0, 4);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  task automatic write_reg(input rgbfx_pkg::cfg_idx_t idx, input logic [COLW-1:0] data);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // wait until every queued item went in and every drive value came out,
  // then let the pipe settle while the sender sits idle
  task automatic drain();
    while (pending_restart.size() != 0 || in_valid || expected_drive.size() != 0)
      @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic play(input int n, input int restart_pct);
    repeat (n) pending_restart.push_back($urandom_range(0, 99) < restart_pct);
    drain();
  endtask

  // fresh mode plus a random subset of the other registers, then items
  task automatic random_phase(input int n);
    int pct;
    write_reg(rgbfx_pkg::REG_MODE, COLW'($urandom_range(0, 3)));
    if ($urandom_range(0, 2) == 0)
      write_reg(rgbfx_pkg::REG_SPEED, COLW'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 7)
                                                                        : $urandom_range(1, 4)));
    if ($urandom_range(0, 2) == 0)
      write_reg(rgbfx_pkg::REG_BRIGHTNESS, COLW'($urandom_range(0, 3)));
    if ($urandom_range(0, 2) == 0) write_reg(rgbfx_pkg::REG_SOLID, rand_color());
    for (int k = 0; k < 4; k++)
      if ($urandom_range(0, 3) == 0)
        write_reg(rgbfx_pkg::cfg_idx_t'(rgbfx_pkg::REG_PAL0 + k), rand_color());
    case ($urandom_range(0, 3))
      0:       pct = 0;
      1:       pct = 2;
      2:       pct = 10;
      default: pct = 50;
    endcase
    play(n, pct);
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // reset state is off mode: ticks, then a restart
    play(2, 0);
    play(1, 100);

    // solid at every brightness, full white down to black
    write_reg(rgbfx_pkg::REG_MODE, COLW'(rgbfx_pkg::MODE_SOLID));
    write_reg(rgbfx_pkg::REG_SOLID, WHITE);
    play(1, 0);
    write_reg(rgbfx_pkg::REG_BRIGHTNESS, COLW'(DIM_QUARTER));
    play(1, 0);
    write_reg(rgbfx_pkg::REG_BRIGHTNESS, COLW'(DIM_HALF));
    play(1, 0);
    write_reg(rgbfx_pkg::REG_BRIGHTNESS, COLW'(DIM_3QUART));
    write_reg(rgbfx_pkg::REG_SOLID, 24'h80FF01);
    play(1, 0);
    write_reg(rgbfx_pkg::REG_SOLID, BLACK);
    play(1, 0);

    // breath at the fastest speed, restart mid-ramp
    write_reg(rgbfx_pkg::REG_PAL0, WHITE);
    write_reg(rgbfx_pkg::REG_PAL1, BLACK);
    write_reg(rgbfx_pkg::REG_PAL2, 24'h123456);
    write_reg(rgbfx_pkg::REG_PAL3, 24'hFEDCBA);
    write_reg(rgbfx_pkg::REG_SPEED, COLW'(SPEED_FAST));
    write_reg(rgbfx_pkg::REG_MODE, COLW'(rgbfx_pkg::MODE_BREATH));
    play(8, 0);
    play(1, 100);

    // neon slowest, then an out-of-range speed (acts as the default)
    write_reg(rgbfx_pkg::REG_SPEED, COLW'(SPEED_SLOW));
    write_reg(rgbfx_pkg::REG_MODE, COLW'(rgbfx_pkg::MODE_NEON));
    play(5, 0);
    write_reg(rgbfx_pkg::REG_SPEED, 24'd7);
    play(3, 0);

    for (int p = 0; p < 4; p++) random_phase($urandom_range(50, 80));

    // clean breath run at the fastest speed: a stretch of the rising ramp
    for (int k = 0; k < 4; k++)
      write_reg(rgbfx_pkg::cfg_idx_t'(rgbfx_pkg::REG_PAL0 + k), rand_color());
    write_reg(rgbfx_pkg::REG_SPEED, COLW'(SPEED_FAST));
    write_reg(rgbfx_pkg::REG_MODE, COLW'(rgbfx_pkg::MODE_BREATH));
    play(1, 100);
    play(120, 0);

    // clean neon run from a restart
    write_reg(rgbfx_pkg::REG_MODE, COLW'(rgbfx_pkg::MODE_NEON));
    play(1, 100);
    play(100, 0);

    // no idling from here on
    idle_on = 1'b0;

    for (int p = 0; p < 2; p++) random_phase($urandom_range(50, 80));

    drain();
    if (mismatch_count == 0 && expected_drive.size() == 0) begin
      $display("rgb_led_effect_generator_core: match");
    end else begin
      $display("rgb_led_effect_generator_core: mismatch");
    end
    $finish;
  end

  // hang guard, many times the slowest legal run
  initial begin
    #200000;
    $display("rgb_led_effect_generator_core: mismatch");
    $finish;
  end

endmodule

@@ rgb_led_effect_generator_core.f @@
rtl/core/rgbfx_pkg.sv
rtl/core/rgb_led_effect_generator_core.sv
rtl/core/rgbfx_chk.sv
dv/tb_top.sv
